[hdl/tst_pkg.sv]
// ---------------------------------------------------------------------------
// tst_pkg: types and helpers for the tapered stroke tangent point pipeline
// Payload structs, fixed widths and the bit-step functions of the square
// root and divider stages.
// ---------------------------------------------------------------------------
package tst_pkg;

	localparam int COORD_W    = 16;
	localparam int RAD_W      = 10;
	localparam int MAG_W      = COORD_W;
	localparam int SUM_W      = 2 * MAG_W + 1;
	localparam int DIST_W     = MAG_W + 1;
	localparam int SQ1_TW     = SUM_W + 1;
	localparam int SQ1_STEPS  = DIST_W;
	localparam int UNIT_W     = 15;
	localparam int UNIT_FRAC  = 14;
	localparam int DIV_STEPS  = UNIT_W;
	localparam int DIV_RW     = 32;
	localparam int DEN_W      = DIST_W + 1;
	localparam int ARG_W      = 2 * UNIT_FRAC + 1;
	localparam int SQ2_TW     = ARG_W + 1;
	localparam int SQ2_STEPS  = UNIT_W;
	localparam int TERM_W     = 32;
	localparam int PROD_W     = TERM_W + RAD_W + 1;
	localparam int TERM_FRAC  = 2 * UNIT_FRAC;
	localparam int NPTS       = 8;
	localparam int PIPE_DEPTH = 3 + SQ1_STEPS + 1 + DIV_STEPS + 2 + SQ2_STEPS + 5;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic        [RAD_W-1:0]   first_radius;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
		logic        [RAD_W-1:0]   second_radius;
	} in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] small_right_x;
		logic signed [COORD_W-1:0] small_right_y;
		logic signed [COORD_W-1:0] small_left_x;
		logic signed [COORD_W-1:0] small_left_y;
		logic signed [COORD_W-1:0] large_left_x;
		logic signed [COORD_W-1:0] large_left_y;
		logic signed [COORD_W-1:0] large_right_x;
		logic signed [COORD_W-1:0] large_right_y;
		logic        [RAD_W-1:0]   small_arc_radius;
		logic        [RAD_W-1:0]   large_arc_radius;
		logic                      degenerate;
	} out_t;

	// per-item context that rides along the whole pipe
	typedef struct packed {
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] y0;
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y1;
		logic        [RAD_W-1:0]   r0;
		logic        [RAD_W-1:0]   r1;
		logic        [MAG_W-1:0]   ax;
		logic        [MAG_W-1:0]   ay;
		logic                      neg_x;
		logic                      neg_y;
		logic                      flat;
		logic                      degen;
	} ctx_t;

	// one root bit of the distance square root: {bit, new remainder}
	function automatic logic [SUM_W:0] sq1_bit(input logic [SUM_W-1:0] rem,
			input logic [DIST_W-1:0] root, input int k);
		logic [SQ1_TW-1:0] t;
		logic              b;
		t = (SQ1_TW'(root) << (k + 1)) + (SQ1_TW'(1) << (2 * k));
		b = ({1'b0, rem} >= t);
		return b ? {1'b1, SUM_W'({1'b0, rem} - t)} : {1'b0, rem};
	endfunction

	// one root bit of the cosine square root: {bit, new remainder}
	function automatic logic [ARG_W:0] sq2_bit(input logic [ARG_W-1:0] rem,
			input logic [UNIT_W-1:0] root, input int k);
		logic [SQ2_TW-1:0] t;
		logic              b;
		t = (SQ2_TW'(root) << (k + 1)) + (SQ2_TW'(1) << (2 * k));
		b = ({1'b0, rem} >= t);
		return b ? {1'b1, ARG_W'({1'b0, rem} - t)} : {1'b0, rem};
	endfunction

	// one quotient bit of the restoring divider: {bit, new remainder}
	function automatic logic [DIV_RW:0] div_bit(input logic [DIV_RW-1:0] rem,
			input logic [DEN_W-1:0] den, input int b);
		logic [DIV_RW:0] t;
		logic            q;
		t = (DIV_RW'(1) == 0) ? '0 : ((DIV_RW+1)'(den) << b);
		q = ({1'b0, rem} >= t);
		return q ? {1'b1, DIV_RW'({1'b0, rem} - t)} : {1'b0, rem};
	endfunction

endpackage

[hdl/tapered_stroke_tangent_points_top.sv]
// ---------------------------------------------------------------------------
// tapered_stroke_tangent_points_top: tangent points of a tapered stroke
// Finds the four outer tangent points joining two circles, with squared
// distance, bit-per-stage square roots and divider, and rounded offsets.
// ---------------------------------------------------------------------------
//  channel | signals                       | beat
//  in      | in_valid, in_ready, in_data   | two circles (centre, radius)
//  out     | out_valid, out_ready, out_data| four tangent points, radii, flag
//
//  one beat per cycle unless out stalls; pipe depth is set by the 17-stage distance
//  square root, the 15-stage divider and the 15-stage cosine square root
//  reset clears only the stage valid bits; data registers are not reset
//  a stall on out freezes the whole pipe and drops in_ready in the same cycle
// ---------------------------------------------------------------------------
module tapered_stroke_tangent_points_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tst_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output tst_pkg::out_t out_data
);
	import tst_pkg::*;

	typedef struct packed {
		ctx_t ctx;
		logic [SUM_W-1:0]  rem;
		logic [DIST_W-1:0] root;
	} sq1_t;

	typedef struct packed {
		ctx_t ctx;
		logic [DIV_RW-1:0] rx;
		logic [DIV_RW-1:0] ry;
		logic [DIV_RW-1:0] rs;
		logic [UNIT_W-1:0] qx;
		logic [UNIT_W-1:0] qy;
		logic [UNIT_W-1:0] qs;
		logic [DEN_W-1:0]  den;
	} dv_t;

	typedef struct packed {
		ctx_t ctx;
		logic signed [UNIT_W:0] ux;
		logic signed [UNIT_W:0] uy;
		logic [UNIT_W-1:0]      s;
		logic [ARG_W-1:0]       rem;
		logic [UNIT_W-1:0]      root;
	} sq2_t;

	logic                  adv;
	logic [PIPE_DEPTH-1:0] vld_q;

	// whole pipe moves together; stalls only when the output beat waits
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	// s1: order circles small first, centre deltas and magnitudes
	ctx_t ctx_s1;
	always_ff @(posedge clk) begin
		logic              swap;
		logic signed [COORD_W:0] dx, dy;
		ctx_t c;
		if (adv) begin
			swap = in_data.second_radius < in_data.first_radius;
			c = '0;
			c.x0 = swap ? in_data.second_x : in_data.first_x;
			c.y0 = swap ? in_data.second_y : in_data.first_y;
			c.r0 = swap ? in_data.second_radius : in_data.first_radius;
			c.x1 = swap ? in_data.first_x : in_data.second_x;
			c.y1 = swap ? in_data.first_y : in_data.second_y;
			c.r1 = swap ? in_data.first_radius : in_data.second_radius;
			dx = {c.x0[COORD_W-1], c.x0} - {c.x1[COORD_W-1], c.x1};
			dy = {c.y0[COORD_W-1], c.y0} - {c.y1[COORD_W-1], c.y1};
			c.neg_x = dx[COORD_W];
			c.neg_y = dy[COORD_W];
			c.ax = MAG_W'(dx[COORD_W] ? -dx : dx);
			c.ay = MAG_W'(dy[COORD_W] ? -dy : dy);
			ctx_s1 <= c;
		end
	end

	// s2: squares
	ctx_t ctx_s2;
	logic [2*MAG_W-1:0] sqx_s2, sqy_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2 <= ctx_s1;
			sqx_s2 <= ctx_s1.ax * ctx_s1.ax;
			sqy_s2 <= ctx_s1.ay * ctx_s1.ay;
		end
	end

	// s3: squared distance
	ctx_t ctx_s3;
	logic [SUM_W-1:0] sum_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3 <= ctx_s2;
			sum_s3 <= SUM_W'(sqx_s2) + SUM_W'(sqy_s2);
		end
	end

	// s4: distance square root, one root bit per stage
	sq1_t sq1_s4 [SQ1_STEPS];
	for (genvar j = 0; j < SQ1_STEPS; j++) begin : g_sq1
		always_ff @(posedge clk) begin
			sq1_t           p;
			logic [SUM_W:0] r;
			if (adv) begin
				if (j == 0) begin
					p.ctx  = ctx_s3;
					p.rem  = sum_s3;
					p.root = '0;
				end else begin
					p = sq1_s4[(j == 0) ? 0 : j-1];
				end
				r = sq1_bit(p.rem, p.root, SQ1_STEPS-1-j);
				p.rem = r[SUM_W-1:0];
				if (r[SUM_W]) begin
					p.root[SQ1_STEPS-1-j] = 1'b1;
				end
				sq1_s4[j] <= p;
			end
		end
	end

	// s5: special cases and divider setup
	dv_t dv_s5;
	always_ff @(posedge clk) begin
		dv_t               p;
		logic [DIST_W-1:0] d;
		logic [RAD_W-1:0]  ns;
		if (adv) begin
			p = '0;
			p.ctx = sq1_s4[SQ1_STEPS-1].ctx;
			d = sq1_s4[SQ1_STEPS-1].root;
			p.ctx.degen = (d == '0);
			p.ctx.flat = (p.ctx.r0 == p.ctx.r1) ||
				((DIST_W+1)'(p.ctx.r0) + (DIST_W+1)'(d) < (DIST_W+1)'(p.ctx.r1));
			ns = p.ctx.flat ? '0 : (p.ctx.r1 - p.ctx.r0);
			p.rx = (DIV_RW'(p.ctx.ax) << UNIT_W) + DIV_RW'(d);
			p.ry = (DIV_RW'(p.ctx.ay) << UNIT_W) + DIV_RW'(d);
			p.rs = (DIV_RW'(ns) << UNIT_W) + DIV_RW'(d);
			p.den = {d, 1'b0};
			dv_s5 <= p;
		end
	end

	// s6: shared-divisor restoring divider, one quotient bit per stage
	dv_t dv_s6 [DIV_STEPS];
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		always_ff @(posedge clk) begin
			dv_t             p;
			logic [DIV_RW:0] rx, ry, rs;
			if (adv) begin
				p = (j == 0) ? dv_s5 : dv_s6[(j == 0) ? 0 : j-1];
				rx = div_bit(p.rx, p.den, DIV_STEPS-1-j);
				ry = div_bit(p.ry, p.den, DIV_STEPS-1-j);
				rs = div_bit(p.rs, p.den, DIV_STEPS-1-j);
				p.rx = rx[DIV_RW-1:0];
				p.ry = ry[DIV_RW-1:0];
				p.rs = rs[DIV_RW-1:0];
				p.qx[DIV_STEPS-1-j] = rx[DIV_RW];
				p.qy[DIV_STEPS-1-j] = ry[DIV_RW];
				p.qs[DIV_STEPS-1-j] = rs[DIV_RW];
				dv_s6[j] <= p;
			end
		end
	end

	// s7: signed unit vector and sine squared
	ctx_t                   ctx_s7;
	logic signed [UNIT_W:0] ux_s7, uy_s7;
	logic [UNIT_W-1:0]      s_s7;
	logic [2*UNIT_W-1:0]    ss_s7;
	always_ff @(posedge clk) begin
		dv_t p;
		if (adv) begin
			p = dv_s6[DIV_STEPS-1];
			ctx_s7 <= p.ctx;
			ux_s7  <= p.ctx.neg_x ? -$signed({1'b0, p.qx}) : $signed({1'b0, p.qx});
			uy_s7  <= p.ctx.neg_y ? -$signed({1'b0, p.qy}) : $signed({1'b0, p.qy});
			s_s7   <= p.qs;
			ss_s7  <= p.qs * p.qs;
		end
	end

	// s8: cosine squared
	sq2_t sq2_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			sq2_s8.ctx  <= ctx_s7;
			sq2_s8.ux   <= ux_s7;
			sq2_s8.uy   <= uy_s7;
			sq2_s8.s    <= s_s7;
			sq2_s8.rem  <= ARG_W'((2*UNIT_W)'(1) << TERM_FRAC) - ARG_W'(ss_s7);
			sq2_s8.root <= '0;
		end
	end

	// s9: cosine square root, one root bit per stage
	sq2_t sq2_s9 [SQ2_STEPS];
	for (genvar j = 0; j < SQ2_STEPS; j++) begin : g_sq2
		always_ff @(posedge clk) begin
			sq2_t           p;
			logic [ARG_W:0] r;
			if (adv) begin
				p = (j == 0) ? sq2_s8 : sq2_s9[(j == 0) ? 0 : j-1];
				r = sq2_bit(p.rem, p.root, SQ2_STEPS-1-j);
				p.rem = r[ARG_W-1:0];
				if (r[ARG_W]) begin
					p.root[SQ2_STEPS-1-j] = 1'b1;
				end
				sq2_s9[j] <= p;
			end
		end
	end

	// s10: sine and cosine times the unit vector
	ctx_t                     ctx_s10;
	logic signed [TERM_W-1:0] psx_s10, psy_s10, pcx_s10, pcy_s10;
	always_ff @(posedge clk) begin
		sq2_t                   p;
		logic signed [UNIT_W:0] ss, cs;
		if (adv) begin
			p = sq2_s9[SQ2_STEPS-1];
			ss = $signed({1'b0, p.s});
			cs = $signed({1'b0, p.root});
			ctx_s10 <= p.ctx;
			psx_s10 <= ss * p.ux;
			psy_s10 <= ss * p.uy;
			pcx_s10 <= cs * p.ux;
			pcy_s10 <= cs * p.uy;
		end
	end

	// s11: right and left direction terms, zero when there is no direction
	ctx_t                     ctx_s11;
	logic signed [TERM_W-1:0] w_s11 [4];
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s11  <= ctx_s10;
			w_s11[0] <= ctx_s10.degen ? '0 : psx_s10 + pcy_s10;
			w_s11[1] <= ctx_s10.degen ? '0 : psy_s10 - pcx_s10;
			w_s11[2] <= ctx_s10.degen ? '0 : psx_s10 - pcy_s10;
			w_s11[3] <= ctx_s10.degen ? '0 : psy_s10 + pcx_s10;
		end
	end

	// s12: radius times direction term, in output order
	ctx_t                     ctx_s12;
	logic signed [PROD_W-1:0] pr_s12 [NPTS];
	always_ff @(posedge clk) begin
		logic signed [RAD_W:0] a, b;
		if (adv) begin
			a = $signed({1'b0, ctx_s11.r0});
			b = $signed({1'b0, ctx_s11.r1});
			ctx_s12   <= ctx_s11;
			pr_s12[0] <= a * w_s11[0];
			pr_s12[1] <= a * w_s11[1];
			pr_s12[2] <= a * w_s11[2];
			pr_s12[3] <= a * w_s11[3];
			pr_s12[4] <= b * w_s11[2];
			pr_s12[5] <= b * w_s11[3];
			pr_s12[6] <= b * w_s11[0];
			pr_s12[7] <= b * w_s11[1];
		end
	end

	// s13: round offsets to the coordinate lsb, halves away from zero
	ctx_t                      ctx_s13;
	logic signed [COORD_W-1:0] off_s13 [NPTS];
	for (genvar i = 0; i < NPTS; i++) begin : g_rnd
		always_ff @(posedge clk) begin
			logic [PROD_W-1:0]  m;
			logic [COORD_W-1:0] q;
			if (adv) begin
				m = pr_s12[i][PROD_W-1] ? PROD_W'(-pr_s12[i]) : PROD_W'(pr_s12[i]);
				q = COORD_W'((m + (PROD_W'(1) << (TERM_FRAC - 1))) >> TERM_FRAC);
				off_s13[i] <= pr_s12[i][PROD_W-1] ? -$signed(q) : $signed(q);
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s13 <= ctx_s12;
		end
	end

	// s14: add to centre and saturate; this is the output register
	always_ff @(posedge clk) begin
		logic signed [COORD_W-1:0] cen [NPTS];
		logic signed [COORD_W:0]   t;
		logic signed [COORD_W-1:0] pt [NPTS];
		if (adv) begin
			cen[0] = ctx_s13.x0; cen[1] = ctx_s13.y0;
			cen[2] = ctx_s13.x0; cen[3] = ctx_s13.y0;
			cen[4] = ctx_s13.x1; cen[5] = ctx_s13.y1;
			cen[6] = ctx_s13.x1; cen[7] = ctx_s13.y1;
			for (int i = 0; i < NPTS; i++) begin
				t = {cen[i][COORD_W-1], cen[i]} + {off_s13[i][COORD_W-1], off_s13[i]};
				if (t[COORD_W] != t[COORD_W-1]) begin
					pt[i] = t[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
						: {1'b0, {(COORD_W-1){1'b1}}};
				end else begin
					pt[i] = t[COORD_W-1:0];
				end
			end
			out_data.small_right_x    <= pt[0];
			out_data.small_right_y    <= pt[1];
			out_data.small_left_x     <= pt[2];
			out_data.small_left_y     <= pt[3];
			out_data.large_left_x     <= pt[4];
			out_data.large_left_y     <= pt[5];
			out_data.large_right_x    <= pt[6];
			out_data.large_right_y    <= pt[7];
			out_data.small_arc_radius <= ctx_s13.r0;
			out_data.large_arc_radius <= ctx_s13.r1;
			out_data.degenerate       <= ctx_s13.degen;
		end
	end

	// coincident centres collapse both points of each circle
	a_degen_pts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |->
			out_data.small_right_x == out_data.small_left_x &&
			out_data.large_left_y == out_data.large_right_y)
		else $error("degenerate beat with distinct tangent points");

	// swap leaves the small circle first
	a_radius_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.small_arc_radius <= out_data.large_arc_radius)
		else $error("radii out of order after swap");

	// a stall freezes every stage valid bit
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipe moved during stall");

endmodule

[sim/tapered_stroke_tangent_points_top_tb.sv]
// ---------------------------------------------------------------------------
// tapered_stroke_tangent_points_top_tb: self-checking bench for the tangent
// point pipeline
// Drives circle pairs over the input channel, predicts the tangent points
// with an independent fixed-point model and checks every output beat in
// order, under random sender and receiver idling and a long output stall.
// ---------------------------------------------------------------------------
module tapered_stroke_tangent_points_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import tst_pkg::*;

	localparam int UNIT       = 16384;
	localparam int LATENCY    = 58;
	localparam longint LIMIT  = 1000000;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	in_t   in_data;
	logic  out_valid;
	logic  out_ready;
	out_t  out_data;

	out_t   tangent_q[$];
	int     errors;
	int     send_idle_pct;
	int     recv_idle_pct;
	bit     recv_hold;
	longint cycle_cnt;

	tapered_stroke_tangent_points_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT) begin
			$display("tapered_stroke_tangent_points_top_tb: FAIL");
			$finish;
		end
	end

	// integer square root, floor
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// rounded num * 2^14 / den, clamped to one
	function automatic longint unit_ratio(input longint num, input longint den);
		longint q, m;
		m = (num < 0) ? -num : num;
		q = ((m << 15) + den) / (den << 1);
		if (q > UNIT) q = UNIT;
		return (num < 0) ? -q : q;
	endfunction

	// r * term / 2^28 rounded halves away from zero
	function automatic longint scale_offset(input longint r, input longint term);
		longint p, m, q;
		p = r * term;
		m = (p < 0) ? -p : p;
		q = (m + (64'sd1 << 27)) >>> 28;
		return (p < 0) ? -q : q;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[COORD_W-1:0];
	endfunction

	// expected tangent points for one circle pair
	function automatic out_t tangent_points(input in_t c);
		out_t   o;
		longint x0, y0, x1, y1, r0, r1, t, dx, dy, d, ux, uy, s, cs;
		longint wrx, wry, wlx, wly;
		x0 = c.first_x;  y0 = c.first_y;  r0 = c.first_radius;
		x1 = c.second_x; y1 = c.second_y; r1 = c.second_radius;
		if (r1 < r0) begin
			t = x0; x0 = x1; x1 = t;
			t = y0; y0 = y1; y1 = t;
			t = r0; r0 = r1; r1 = t;
		end
		dx = x0 - x1;
		dy = y0 - y1;
		d  = int_sqrt(dx * dx + dy * dy);
		o.degenerate = (d == 0);
		if (d == 0) begin
			wrx = 0; wry = 0; wlx = 0; wly = 0;
		end else begin
			ux = unit_ratio(dx, d);
			uy = unit_ratio(dy, d);
			if (r0 == r1 || r0 + d < r1) begin
				s  = 0;
				cs = UNIT;
			end else begin
				s  = unit_ratio(r1 - r0, d);
				cs = int_sqrt(64'd268435456 - s * s);
			end
			wrx = s * ux + cs * uy;
			wry = s * uy - cs * ux;
			wlx = s * ux - cs * uy;
			wly = s * uy + cs * ux;
		end
		o.small_right_x    = clamp_coord(x0 + scale_offset(r0, wrx));
		o.small_right_y    = clamp_coord(y0 + scale_offset(r0, wry));
		o.small_left_x     = clamp_coord(x0 + scale_offset(r0, wlx));
		o.small_left_y     = clamp_coord(y0 + scale_offset(r0, wly));
		o.large_left_x     = clamp_coord(x1 + scale_offset(r1, wlx));
		o.large_left_y     = clamp_coord(y1 + scale_offset(r1, wly));
		o.large_right_x    = clamp_coord(x1 + scale_offset(r1, wrx));
		o.large_right_y    = clamp_coord(y1 + scale_offset(r1, wry));
		o.small_arc_radius = r0[RAD_W-1:0];
		o.large_arc_radius = r1[RAD_W-1:0];
		return o;
	endfunction

	// send one circle pair, with random idle cycles before it
	task automatic send_pair(input in_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tangent_q.push_back(tangent_points(c));
	endtask

	// receiver: random idling, or a long hold-off when asked
	always @(posedge clk) begin
		if (recv_hold)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// check each output beat against the oldest expectation
	always @(posedge clk) begin
		out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (tangent_q.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, out_data);
				errors++;
			end else begin
				e = tangent_q.pop_front();
				if (e.small_right_x !== out_data.small_right_x) begin
					$display("%0t: small_right_x exp %0d got %0d", $time,
						e.small_right_x, out_data.small_right_x); errors++;
				end
				if (e.small_right_y !== out_data.small_right_y) begin
					$display("%0t: small_right_y exp %0d got %0d", $time,
						e.small_right_y, out_data.small_right_y); errors++;
				end
				if (e.small_left_x !== out_data.small_left_x) begin
					$display("%0t: small_left_x exp %0d got %0d", $time,
						e.small_left_x, out_data.small_left_x); errors++;
				end
				if (e.small_left_y !== out_data.small_left_y) begin
					$display("%0t: small_left_y exp %0d got %0d", $time,
						e.small_left_y, out_data.small_left_y); errors++;
				end
				if (e.large_left_x !== out_data.large_left_x) begin
					$display("%0t: large_left_x exp %0d got %0d", $time,
						e.large_left_x, out_data.large_left_x); errors++;
				end
				if (e.large_left_y !== out_data.large_left_y) begin
					$display("%0t: large_left_y exp %0d got %0d", $time,
						e.large_left_y, out_data.large_left_y); errors++;
				end
				if (e.large_right_x !== out_data.large_right_x) begin
					$display("%0t: large_right_x exp %0d got %0d", $time,
						e.large_right_x, out_data.large_right_x); errors++;
				end
				if (e.large_right_y !== out_data.large_right_y) begin
					$display("%0t: large_right_y exp %0d got %0d", $time,
						e.large_right_y, out_data.large_right_y); errors++;
				end
				if (e.small_arc_radius !== out_data.small_arc_radius) begin
					$display("%0t: small_arc_radius exp %0d got %0d", $time,
						e.small_arc_radius, out_data.small_arc_radius); errors++;
				end
				if (e.large_arc_radius !== out_data.large_arc_radius) begin
					$display("%0t: large_arc_radius exp %0d got %0d", $time,
						e.large_arc_radius, out_data.large_arc_radius); errors++;
				end
				if (e.degenerate !== out_data.degenerate) begin
					$display("%0t: degenerate exp %0d got %0d", $time,
						e.degenerate, out_data.degenerate); errors++;
				end
			end
		end
	end

	function automatic in_t make_pair(input int x0, input int y0, input int r0,
			input int x1, input int y1, input int r1);
		in_t c;
		c.first_x  = x0[15:0]; c.first_y  = y0[15:0]; c.first_radius  = r0[9:0];
		c.second_x = x1[15:0]; c.second_y = y1[15:0]; c.second_radius = r1[9:0];
		return c;
	endfunction

	// random coordinate: full range, or near a base point
	function automatic int rand_coord(input int base, input int spread);
		if ($urandom_range(3) == 0)
			return int'($urandom_range(65535)) - 32768;
		return base + int'($urandom_range(2 * spread)) - spread;
	endfunction

	function automatic in_t random_pair();
		int x0, y0, spread;
		x0     = int'($urandom_range(65535)) - 32768;
		y0     = int'($urandom_range(65535)) - 32768;
		spread = ($urandom_range(1)) ? 64 : 2048;
		case ($urandom_range(5))
			0: return make_pair(x0, y0, $urandom_range(1023), x0, y0, $urandom_range(1023));
			1: return make_pair(x0, y0, 500, rand_coord(x0, spread), rand_coord(y0, spread), 500);
			default: return make_pair(x0, y0, $urandom_range(1023),
				rand_coord(x0, spread), rand_coord(y0, spread), $urandom_range(1023));
		endcase
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tangent_q.size() != 0) @(posedge clk);
	endtask

	// extremes and special cases
	task automatic test_directed();
		send_pair(make_pair(0, 0, 0, 0, 0, 0));
		send_pair(make_pair(100, -50, 300, 100, -50, 700));
		send_pair(make_pair(0, 0, 160, 1600, 0, 160));
		send_pair(make_pair(0, 0, 160, 0, 1600, 480));
		send_pair(make_pair(0, 0, 800, 40, 30, 100));
		send_pair(make_pair(500, 500, 0, -500, 200, 900));
		send_pair(make_pair(0, 0, 1023, 10, 0, 1022));
		send_pair(make_pair(32767, 32767, 1023, -32768, -32768, 0));
		send_pair(make_pair(-32768, -32768, 1023, 32767, 32767, 1023));
		send_pair(make_pair(32767, -32768, 1023, 32767, -32767, 1));
		send_pair(make_pair(32767, 0, 1023, 32000, 0, 512));
		send_pair(make_pair(-32768, 0, 1023, -32768, 10, 1023));
		send_pair(make_pair(0, 0, 300, 3, 4, 305));
		send_pair(make_pair(1, 1, 512, 0, 0, 511));
		send_pair(make_pair(-7, 13, 64, -7, 14, 1000));
		send_pair(make_pair(21845, -21846, 682, -10923, 10922, 341));
		wait_drained();
	endtask

	task automatic test_random(input int n, input int sidle, input int ridle);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		repeat (n) send_pair(random_pair());
	endtask

	// hold the receiver off until the pipe backs up into the input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold     = 1'b1;
		fork
			begin
				repeat (3 * LATENCY) @(posedge clk);
				recv_hold = 1'b0;
			end
			repeat (120) send_pair(random_pair());
		join
		// sender pauses until everything is out
		wait_drained();
	endtask

	initial begin
		errors        = 0;
		cycle_cnt     = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold     = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		out_ready     = 1'b0;
		arst_n        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(500, 31, 61);
		test_backpressure();
		test_random(500, 61, 31);
		test_random(550, 0, 0);

		wait_drained();
		repeat (2 * LATENCY) @(posedge clk);
		if (errors == 0 && tangent_q.size() == 0)
			$display("tapered_stroke_tangent_points_top_tb: PASS");
		else
			$display("tapered_stroke_tangent_points_top_tb: FAIL");
		$finish;
	end

endmodule
